// ----- hdl/rlhc_pkg.sv -----
// Package for the reference-counted handle cache.
// Holds operation, status, path and controller command codes. No dependencies.
package rlhc_pkg;
  localparam logic [1:0] OP_GET = 2'd0;
  localparam logic [1:0] OP_PUT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FD_FAIL = 3'd1;
  localparam logic [2:0] ST_DB_FAIL = 3'd2;
  localparam logic [2:0] ST_BAD_PUT = 3'd3;
  localparam logic [2:0] ST_IN_USE = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  localparam logic [2:0] PA_HIT = 3'd0;
  localparam logic [2:0] PA_FRESH = 3'd1;
  localparam logic [2:0] PA_EVICT = 3'd2;
  localparam logic [2:0] PA_BYPASS = 3'd3;
  localparam logic [2:0] PA_RELEASED = 3'd4;
  localparam logic [2:0] PA_REMOVED = 3'd5;
  localparam logic [2:0] PA_RMISS = 3'd6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input transaction and reset the key search
    logic search;   // one step of the key search
    logic fetch;    // registered reads of the operands for the decision
    logic exec;     // decide and update state
    logic qstep;    // one step of an idle queue removal
  } rlhc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_done;
    logic q_busy;
  } rlhc_sts_t;
endpackage

// ----- hdl/rlhc_datapath.sv -----
// Datapath of the handle cache: slot tables, key search, idle queue, free stack.
// Depends on rlhc_pkg.
module rlhc_datapath #(
  parameter int ENTRIES = 64,
  parameter int REF_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rlhc_pkg::rlhc_cmd_t    cmd,
  output rlhc_pkg::rlhc_sts_t    sts,
  input  logic [1:0]             in_op,
  input  logic [31:0]            in_coll_id,
  input  logic [63:0]            in_obj_handle,
  input  logic                   in_want_fd,
  input  logic                   in_want_db,
  input  logic                   in_create,
  input  logic                   in_fd_fails,
  input  logic                   in_db_fails,
  input  logic [5:0]             in_ref_slot,
  input  logic                   in_ref_cached,
  output logic [2:0]             res_status,
  output logic [2:0]             res_path,
  output logic [5:0]             res_slot,
  output logic                   res_open_fd,
  output logic                   res_open_db,
  output logic                   res_close_fd,
  output logic                   res_close_db,
  output logic                   res_create
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  // Per-slot control state in flip-flops; keys in memories.
  logic [ENTRIES-1:0]  valid_r, fdo_r, dbo_r;
  logic [REF_BITS-1:0] refs_r [ENTRIES];
  logic [31:0]         coll_mem [ENTRIES];
  logic [63:0]         hnd_mem [ENTRIES];
  logic [IW-1:0]       idle_mem [ENTRIES];
  logic [IW-1:0]       free_mem [ENTRIES];
  logic [CW-1:0]       idle_cnt_r, free_cnt_r;
  // Stack positions below this mark were never pushed and hold their own index.
  logic [CW-1:0]       free_wm_r;

  // Captured transaction.
  logic [1:0]  op_r;
  logic [31:0] coll_r;
  logic [63:0] hnd_r;
  logic        wfd_r, wdb_r, cre_r, ffail_r, dfail_r, rcached_r;
  logic [5:0]  rslot_r;

  // Key search: one entry per cycle, read data registered.
  logic [CW-1:0] scan_r;
  logic          found_r, rd_v_r;
  logic [IW-1:0] found_idx_r, rd_idx_r;
  logic [31:0]   rd_coll_r;
  logic [63:0]   rd_hnd_r;
  logic          search_done_r;

  // Idle queue removal: shift entries after the victim one per cycle.
  logic          q_busy_r;
  logic [IW-1:0] q_victim_r;
  logic [CW-1:0] q_pos_r;
  logic          q_found_r;
  logic [IW-1:0] q_rd_r;
  logic [CW-1:0] q_rd_pos_r;
  logic          q_rd_v_r;

  // Operands read in the fetch cycle.
  logic [IW-1:0]       free_top_r, idle_head_r;
  logic [REF_BITS-1:0] sel_refs_r;
  logic [CW-1:0]       free_pos;
  logic [IW-1:0]       sel_idx;

  assign free_pos = free_cnt_r - 1'b1;
  assign sel_idx = (op_r == rlhc_pkg::OP_PUT) ? IW'(rslot_r) : found_idx_r;

  assign sts.search_done = search_done_r;
  assign sts.q_busy = q_busy_r;

  // Search pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_done_r <= 1'b0;
      found_r <= 1'b0;
      rd_v_r <= 1'b0;
      scan_r <= '0;
    end else if (cmd.load) begin
      op_r <= in_op; coll_r <= in_coll_id; hnd_r <= in_obj_handle;
      wfd_r <= in_want_fd; wdb_r <= in_want_db; cre_r <= in_create;
      ffail_r <= in_fd_fails; dfail_r <= in_db_fails;
      rslot_r <= in_ref_slot; rcached_r <= in_ref_cached;
      scan_r <= '0;
      found_r <= 1'b0;
      rd_v_r <= 1'b0;
      search_done_r <= 1'b0;
    end else if (cmd.search) begin
      if (scan_r < FULL) begin
        rd_coll_r <= coll_mem[scan_r[IW-1:0]];
        rd_hnd_r <= hnd_mem[scan_r[IW-1:0]];
        rd_idx_r <= scan_r[IW-1:0];
        rd_v_r <= valid_r[scan_r[IW-1:0]];
        scan_r <= scan_r + 1'b1;
      end else begin
        rd_v_r <= 1'b0;
      end
      if (rd_v_r && !found_r && rd_coll_r == coll_r && rd_hnd_r == hnd_r) begin
        found_r <= 1'b1;
        found_idx_r <= rd_idx_r;
      end
      if (scan_r == FULL && !rd_v_r) search_done_r <= 1'b1;
    end
  end

  // Operand fetch: registered reads of the stack top, the queue head and
  // the reference count of the slot concerned.
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      free_top_r <= (free_pos < free_wm_r) ? IW'(free_pos) : free_mem[IW'(free_pos)];
      idle_head_r <= idle_mem[0];
      sel_refs_r <= refs_r[sel_idx];
    end
  end

  // Decision and state update.
  always_ff @(posedge clk) begin
    logic [IW-1:0] s;
    logic ok, rs_ok;
    s = found_idx_r;
    ok = 1'b1;
    rs_ok = 1'b0;
    if (!rst_n) begin
      valid_r <= '0; fdo_r <= '0; dbo_r <= '0;
      for (int i = 0; i < ENTRIES; i++) refs_r[i] <= '0;
      idle_cnt_r <= '0;
      free_cnt_r <= FULL;
      free_wm_r <= FULL;
      q_busy_r <= 1'b0;
      q_rd_v_r <= 1'b0;
    end else if (cmd.exec) begin
      res_status <= rlhc_pkg::ST_OK; res_path <= rlhc_pkg::PA_HIT; res_slot <= '0;
      res_open_fd <= 1'b0; res_open_db <= 1'b0;
      res_close_fd <= 1'b0; res_close_db <= 1'b0; res_create <= 1'b0;
      case (op_r)
        rlhc_pkg::OP_GET: begin
          if (found_r) begin
            res_slot <= 6'(s);
            if (sel_refs_r == REF_MAX) begin
              res_status <= rlhc_pkg::ST_OVERFLOW;
            end else begin
              if (wfd_r && !fdo_r[s]) begin
                res_open_fd <= 1'b1; res_create <= cre_r;
                if (ffail_r) begin
                  res_status <= rlhc_pkg::ST_FD_FAIL; ok = 1'b0;
                end else fdo_r[s] <= 1'b1;
              end
              if (ok && wdb_r && !dbo_r[s]) begin
                res_open_db <= 1'b1; res_create <= cre_r;
                if (dfail_r) begin
                  res_status <= rlhc_pkg::ST_DB_FAIL; ok = 1'b0;
                end else dbo_r[s] <= 1'b1;
              end
              if (ok) begin
                if (sel_refs_r == '0) begin
                  q_busy_r <= 1'b1; q_victim_r <= s; q_pos_r <= '0; q_found_r <= 1'b0;
                end
                refs_r[s] <= sel_refs_r + 1'b1;
              end
            end
          end else if (free_cnt_r != '0 || idle_cnt_r != '0) begin
            if (wfd_r) begin
              res_open_fd <= 1'b1; res_create <= cre_r;
              if (ffail_r) begin res_status <= rlhc_pkg::ST_FD_FAIL; ok = 1'b0; end
            end
            if (ok && wdb_r) begin
              res_open_db <= 1'b1; res_create <= cre_r;
              if (dfail_r) begin res_status <= rlhc_pkg::ST_DB_FAIL; ok = 1'b0; end
            end
            if (free_cnt_r != '0) begin
              s = free_top_r;
              res_path <= rlhc_pkg::PA_FRESH;
              // A failed open puts the slot back on top: the stack is unchanged.
              if (ok) free_cnt_r <= free_cnt_r - 1'b1;
            end else begin
              s = idle_head_r;
              res_path <= rlhc_pkg::PA_EVICT;
              res_close_fd <= fdo_r[s]; res_close_db <= dbo_r[s];
              q_busy_r <= 1'b1; q_victim_r <= s; q_pos_r <= '0; q_found_r <= 1'b0;
              if (!ok) begin
                free_mem[IW'(free_cnt_r)] <= s;
                if (free_cnt_r < free_wm_r) free_wm_r <= free_cnt_r;
                free_cnt_r <= free_cnt_r + 1'b1;
              end
            end
            res_slot <= 6'(s);
            coll_mem[s] <= coll_r;
            hnd_mem[s] <= hnd_r;
            valid_r[s] <= ok;
            refs_r[s] <= ok ? REF_BITS'(1) : '0;
            fdo_r[s] <= ok & wfd_r;
            dbo_r[s] <= ok & wdb_r;
          end else begin
            res_path <= rlhc_pkg::PA_BYPASS;
            if (wfd_r) begin
              res_open_fd <= 1'b1; res_create <= cre_r;
              if (ffail_r) begin res_status <= rlhc_pkg::ST_FD_FAIL; ok = 1'b0; end
            end
            if (ok && wdb_r) begin
              res_open_db <= 1'b1; res_create <= cre_r;
              if (dfail_r) res_status <= rlhc_pkg::ST_DB_FAIL;
            end
          end
        end
        rlhc_pkg::OP_PUT: begin
          res_path <= rlhc_pkg::PA_RELEASED;
          if (rcached_r) begin
            res_slot <= rslot_r;
            if (32'(rslot_r) < ENTRIES) rs_ok = 1'b1;
            s = IW'(rslot_r);
            if (!rs_ok || !valid_r[s] || sel_refs_r == '0) begin
              res_status <= rlhc_pkg::ST_BAD_PUT;
            end else begin
              refs_r[s] <= sel_refs_r - 1'b1;
              if (sel_refs_r == REF_BITS'(1) && idle_cnt_r < FULL) begin
                idle_mem[IW'(idle_cnt_r)] <= s;
                idle_cnt_r <= idle_cnt_r + 1'b1;
              end
            end
          end else begin
            res_close_fd <= wfd_r; res_close_db <= wdb_r;
          end
        end
        default: begin
          if (!found_r) begin
            res_path <= rlhc_pkg::PA_RMISS;
          end else begin
            res_path <= rlhc_pkg::PA_REMOVED;
            res_slot <= 6'(s);
            if (sel_refs_r != '0) begin
              res_status <= rlhc_pkg::ST_IN_USE;
            end else begin
              q_busy_r <= 1'b1; q_victim_r <= s; q_pos_r <= '0; q_found_r <= 1'b0;
              res_close_fd <= fdo_r[s]; res_close_db <= dbo_r[s];
              valid_r[s] <= 1'b0; fdo_r[s] <= 1'b0; dbo_r[s] <= 1'b0;
              if (free_cnt_r < FULL) begin
                free_mem[IW'(free_cnt_r)] <= s;
                if (free_cnt_r < free_wm_r) free_wm_r <= free_cnt_r;
                free_cnt_r <= free_cnt_r + 1'b1;
              end
            end
          end
        end
      endcase
    end else if (cmd.qstep && q_busy_r) begin
      // Read one queue entry per cycle; the gap left by the victim closes
      // one read behind.
      if (q_pos_r < idle_cnt_r) begin
        q_rd_r <= idle_mem[IW'(q_pos_r)];
        q_rd_pos_r <= q_pos_r;
        q_rd_v_r <= 1'b1;
        q_pos_r <= q_pos_r + 1'b1;
      end else begin
        q_rd_v_r <= 1'b0;
      end
      if (q_rd_v_r) begin
        if (q_found_r) idle_mem[IW'(q_rd_pos_r - 1'b1)] <= q_rd_r;
        else if (q_rd_r == q_victim_r) q_found_r <= 1'b1;
      end else if (q_pos_r >= idle_cnt_r) begin
        if (q_found_r) idle_cnt_r <= idle_cnt_r - 1'b1;
        q_busy_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_idle_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idle_cnt_r <= FULL) else $error("idle count over depth");
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= FULL) else $error("free count over depth");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !q_busy_r) else $error("execute during queue walk");
`endif
endmodule

// ----- hdl/rlhc_ctrl.sv -----
// Controller of the handle cache: sequences load, search, fetch, execute, queue walk and output.
// Depends on rlhc_pkg.
module rlhc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_op,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output rlhc_pkg::rlhc_cmd_t cmd,
  input  rlhc_pkg::rlhc_sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_QWALK = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;
  localparam logic [2:0] S_FETCH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       take;

  assign in_stall = (state_r != S_IDLE) || out_valid_r;
  assign take = in_valid && !in_stall && in_op != rlhc_pkg::OP_NONE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          cmd.load = 1'b1;
          state_nxt = (in_op == rlhc_pkg::OP_PUT) ? S_FETCH : S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.search_done) begin
          cmd.search = 1'b0;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_QWALK;
      end
      S_QWALK: begin
        cmd.qstep = 1'b1;
        if (!sts.q_busy) state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cmd) <= 1) else $error("more than one command");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE && !out_valid_r) else $error("load while busy");
  a_exec_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |=> out_valid_r) else $error("result lost");
`endif
endmodule

// ----- hdl/refcounted_lru_handle_cache_unit.sv -----
// Top level of the reference-counted handle cache.
// Instantiates rlhc_ctrl and rlhc_datapath; depends on rlhc_pkg.
//
// Usage: one input channel (in_valid/in_stall plus the request fields) and
// one result channel (out_valid/out_stall plus the result fields). Every get,
// put or remove gives exactly one result; op code 3 is accepted and dropped.
// Get and remove first scan the key table one slot per cycle through the key
// memory read port, then fetch their operands and decide; a put skips the
// scan. Any operation that takes a slot out of the idle queue adds a walk
// over the queue before its result is offered.
// One transaction is in flight at a time; the next is taken at the edge after
// the result register has been emptied.
// After reset every slot is free and the idle queue is empty; no clearing
// pass is needed. When the receiver stalls, the result stays in the output
// register and the input stays stalled until it is taken.
module refcounted_lru_handle_cache_unit #(
  parameter int ENTRIES = 64,
  parameter int REF_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_coll_id,
  input  logic [63:0] in_obj_handle,
  input  logic        in_want_fd,
  input  logic        in_want_db,
  input  logic        in_create,
  input  logic        in_fd_fails,
  input  logic        in_db_fails,
  input  logic [5:0]  in_ref_slot,
  input  logic        in_ref_cached,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_path,
  output logic [5:0]  out_slot,
  output logic        out_do_open_fd,
  output logic        out_do_open_db,
  output logic        out_do_close_fd,
  output logic        out_do_close_db,
  output logic        out_open_create
);
  rlhc_pkg::rlhc_cmd_t cmd;
  rlhc_pkg::rlhc_sts_t sts;

  // Sequencing of one transaction.
  rlhc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_op(in_op),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .sts(sts)
  );

  // Tables, queues and the result register.
  rlhc_datapath #(.ENTRIES(ENTRIES), .REF_BITS(REF_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_op(in_op), .in_coll_id(in_coll_id), .in_obj_handle(in_obj_handle),
    .in_want_fd(in_want_fd), .in_want_db(in_want_db), .in_create(in_create),
    .in_fd_fails(in_fd_fails), .in_db_fails(in_db_fails),
    .in_ref_slot(in_ref_slot), .in_ref_cached(in_ref_cached),
    .res_status(out_status), .res_path(out_path), .res_slot(out_slot),
    .res_open_fd(out_do_open_fd), .res_open_db(out_do_open_db),
    .res_close_fd(out_do_close_fd), .res_close_db(out_do_close_db),
    .res_create(out_open_create)
  );
endmodule
